@@ sv/brbs_pkg.sv @@
// Shared types, request codes and position arithmetic for the byte ring buffer.
// No dependencies; imported by brbs_store, byte_ring_buffer_with_search_top and the testbench.
package brbs_pkg;

  localparam int DEPTH       = 256;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int MAX_PATTERN = 8;
  localparam int PLEN_W      = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [3:0] REQ_LOAD  = 4'd0;
  localparam logic [3:0] REQ_GET   = 4'd1;
  localparam logic [3:0] REQ_PEEK  = 4'd2;
  localparam logic [3:0] REQ_ADV   = 4'd3;
  localparam logic [3:0] REQ_FLUSH = 4'd4;
  localparam logic [3:0] REQ_COUNT = 4'd5;
  localparam logic [3:0] REQ_FIND  = 4'd6;
  localparam logic [3:0] REQ_SKIP  = 4'd7;
  localparam logic [3:0] REQ_CLEAR = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_W'(2)) r = SIZE_W'(2);
    if (s > SIZE_W'(DEPTH)) r = SIZE_W'(DEPTH);
    return r;
  endfunction

  function automatic logic [PLEN_W-1:0] eff_plen(input logic [PLEN_W-1:0] n);
    logic [PLEN_W-1:0] r;
    r = n;
    if (n == '0) r = PLEN_W'(1);
    if (n > PLEN_W'(MAX_PATTERN)) r = PLEN_W'(MAX_PATTERN);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p,
                                                 input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] n;
    n = {1'b0, p} + SIZE_W'(1);
    return (n >= s) ? '0 : n[ADDR_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] occ_of(input logic [ADDR_W-1:0] r,
                                               input logic [ADDR_W-1:0] w,
                                               input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] o;
    if (w >= r) o = {1'b0, w} - {1'b0, r};
    else        o = s - {1'b0, r} + {1'b0, w};
    return o;
  endfunction

endpackage

@@ sv/brbs_store.sv @@
// Byte store of the ring buffer: one write port, one registered read port,
// per-entry valid bits so an unwritten or cleared entry reads as zero. Uses brbs_pkg.
module brbs_store (
  input  logic                          clk,
  input  logic                          rst,
  input  brbs_pkg::store_req_t          req,
  output logic [7:0]                    rdata
);
  import brbs_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_q <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rvalid_q <= valid[req.raddr];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : 8'd0;

endmodule

@@ sv/byte_ring_buffer_with_search_top.sv @@
// Byte ring buffer with count and pattern search. Load, advance, flush, clear, unknown
// requests and get or peek when empty go from idle straight to done; get and peek otherwise
// fetch and evaluate one byte; count, find and advance to pattern fetch and evaluate each
// byte walked (up to occupancy). One request at a time; the next is taken the cycle after the
// result word is loaded, and the done state holds the word back while the last word stalls.
// Reset (rst, synchronous) empties the buffer, zeroes the store and restores registers.
module byte_ring_buffer_with_search_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          req_type,
  input  logic [7:0]                          data_byte,
  input  logic [8:0]                          advance_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          read_byte,
  output logic                                flag,
  output logic [7:0]                          match_count,
  output logic [7:0]                          occupancy,
  output logic                                is_empty,
  input  logic                                cfg_we,
  input  logic [brbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brbs_pkg::CFG_W-1:0]          cfg_data
);
  import brbs_pkg::*;

  state_t             state;
  logic [3:0]         req;
  logic [7:0]         db;
  logic [ADDR_W-1:0]  rd_pos;
  logic [ADDR_W-1:0]  wr_pos;
  logic [ADDR_W-1:0]  scan_pos;
  logic [PLEN_W-1:0]  m;
  logic [SIZE_W-1:0]  size_reg;
  logic [CFG_W-1:0]   pat_reg;
  logic [PLEN_W-1:0]  plen_reg;
  logic [7:0]         res_byte;
  logic               res_flag;
  logic [7:0]         res_count;

  store_req_t         st_req;
  logic [7:0]         st_rdata;

  logic               accept;
  logic               out_free;
  logic [SIZE_W-1:0]  size_eff;
  logic [PLEN_W-1:0]  plen_eff;
  logic [ADDR_W-1:0]  wr_next;
  logic [ADDR_W-1:0]  scan_next;
  logic [SIZE_W-1:0]  occ_now;
  logic [SIZE_W-1:0]  adv_len;
  logic [SIZE_W-1:0]  adv_sum;
  logic [7:0]         cmp_ref;
  logic               cmp_hit;
  logic               first_hit;
  logic [PLEN_W-1:0]  m_next;

  brbs_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (st_req),
    .rdata (st_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign size_eff = eff_size(size_reg);
  assign plen_eff = eff_plen(plen_reg);
  assign wr_next  = next_pos(wr_pos, size_eff);
  assign scan_next = next_pos(scan_pos, size_eff);
  assign occ_now  = occ_of(rd_pos, wr_pos, size_eff);

  always_comb begin
    adv_len = (advance_len > occ_now) ? occ_now : advance_len;
    adv_sum = {1'b0, rd_pos} + adv_len;
    if (adv_sum >= size_eff) adv_sum = adv_sum - size_eff;
  end

  // shared byte comparator
  always_comb begin
    cmp_ref   = (req == REQ_COUNT) ? db : pat_reg[{m[2:0], 3'b000} +: 8];
    cmp_hit   = (st_rdata == cmp_ref);
    first_hit = (st_rdata == pat_reg[7:0]);
    if (cmp_hit)        m_next = m + PLEN_W'(1);
    else if (first_hit) m_next = PLEN_W'(1);
    else                m_next = '0;
  end

  always_comb begin
    st_req       = '0;
    st_req.we    = accept && (req_type == REQ_LOAD);
    st_req.clr   = accept && (req_type == REQ_CLEAR);
    st_req.re    = (state == S_FETCH);
    st_req.waddr = wr_pos;
    st_req.wdata = data_byte;
    st_req.raddr = scan_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pos    <= '0;
      wr_pos    <= '0;
      size_reg  <= SIZE_W'(DEPTH);
      pat_reg   <= '0;
      plen_reg  <= PLEN_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req       <= req_type;
            db        <= data_byte;
            res_byte  <= '0;
            res_flag  <= (req_type == REQ_LOAD) && (wr_next == rd_pos);
            res_count <= '0;
            m         <= '0;
            scan_pos  <= rd_pos;
            state     <= ((req_type inside {REQ_GET, REQ_PEEK, REQ_COUNT, REQ_FIND, REQ_SKIP})
                          && (rd_pos != wr_pos)) ? S_FETCH : S_DONE;
            case (req_type)
              REQ_LOAD:  wr_pos <= wr_next;
              REQ_ADV:   rd_pos <= adv_sum[ADDR_W-1:0];
              REQ_FLUSH: rd_pos <= wr_pos;
              REQ_CLEAR: begin
                rd_pos <= '0;
                wr_pos <= '0;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: state <= S_EVAL;
        S_EVAL: begin
          case (req)
            REQ_GET: begin
              res_byte <= st_rdata;
              rd_pos   <= scan_next;
              state    <= S_DONE;
            end
            REQ_PEEK: begin
              res_byte <= st_rdata;
              state    <= S_DONE;
            end
            REQ_COUNT: begin
              if (cmp_hit) res_count <= res_count + 8'd1;
              scan_pos <= scan_next;
              state    <= (scan_next != wr_pos) ? S_FETCH : S_DONE;
            end
            REQ_FIND: begin
              m <= m_next;
              if (m_next >= plen_eff) begin
                res_flag <= 1'b1;
                state    <= S_DONE;
              end else begin
                scan_pos <= scan_next;
                state    <= (scan_next != wr_pos) ? S_FETCH : S_DONE;
              end
            end
            REQ_SKIP: begin
              m        <= m_next;
              rd_pos   <= scan_next;
              scan_pos <= scan_next;
              if (m_next >= plen_eff) begin
                res_flag <= 1'b1;
                state    <= S_DONE;
              end else begin
                state    <= (scan_next != wr_pos) ? S_FETCH : S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            read_byte   <= res_byte;
            flag        <= res_flag;
            match_count <= res_count;
            occupancy   <= occ_now[7:0];
            is_empty    <= (rd_pos == wr_pos);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE: begin
            size_reg <= cfg_data[SIZE_W-1:0];
            rd_pos   <= '0;
            wr_pos   <= '0;
          end
          CFG_PATTERN: pat_reg  <= cfg_data;
          CFG_PLEN:    plen_reg <= cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rd_pos} < size_eff) && ({1'b0, wr_pos} < size_eff))
    else $error("ring position beyond buffer size");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> out_valid && (state == S_IDLE))
    else $error("result word not loaded on leaving done");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (occupancy == 8'd0)))
    else $error("empty flag disagrees with occupancy");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (scan_pos != wr_pos))
    else $error("walk fetched past write position");
`endif

endmodule

@@ dv/tb_byte_ring_buffer_with_search_top.sv @@
// Testbench for byte_ring_buffer_with_search_top: a scoreboard class mirrors the ring,
// its indexes and registers, and checks every result word against its own prediction.
// Depends on brbs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_byte_ring_buffer_with_search_top;
  import brbs_pkg::*;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       flag;
    logic [7:0] match_count;
    logic [7:0] occupancy;
    logic       is_empty;
  } ring_word_t;

  class ring_scoreboard;
    bit [7:0]        store [DEPTH];
    bit [ADDR_W-1:0] rd_pos;
    bit [ADDR_W-1:0] wr_pos;
    bit [8:0]        size_reg = 9'd256;
    bit [63:0]       pattern;
    bit [3:0]        plen_reg = 4'd1;
    ring_word_t      expected_words[$];
    int              errors;

    function int ring_span();
      int s;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > DEPTH) s = DEPTH;
      return s;
    endfunction

    function int pattern_len();
      int n;
      n = plen_reg;
      if (n < 1) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
    endfunction

    function bit [7:0] pattern_byte(int i);
      return pattern[(i % 8) * 8 +: 8];
    endfunction

    function int step_pos(int p);
      return (p + 1 >= ring_span()) ? 0 : p + 1;
    endfunction

    function int fill_level();
      if (wr_pos >= rd_pos) return int'(wr_pos) - int'(rd_pos);
      return ring_span() - int'(rd_pos) + int'(wr_pos);
    endfunction

    function int match_advance(int m, bit [7:0] b);
      if (b == pattern_byte(m)) return m + 1;
      if (b == pattern_byte(0)) return 1;
      return 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SIZE: begin
          size_reg = data[8:0];
          rd_pos = '0;
          wr_pos = '0;
        end
        CFG_PATTERN: pattern = data;
        CFG_PLEN: plen_reg = data[3:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [3:0] req, logic [7:0] db, logic [8:0] alen);
      ring_word_t r;
      int p, m, n, plen;
      r = '0;
      n = 0;
      m = 0;
      plen = pattern_len();
      case (req)
        REQ_LOAD: begin
          store[wr_pos] = db;
          wr_pos = ADDR_W'(step_pos(wr_pos));
          r.flag = (wr_pos == rd_pos);
        end
        REQ_GET, REQ_PEEK: begin
          if (rd_pos != wr_pos) begin
            r.read_byte = store[rd_pos];
            if (req == REQ_GET) rd_pos = ADDR_W'(step_pos(rd_pos));
          end
        end
        REQ_ADV: begin
          n = (alen > fill_level()) ? fill_level() : alen;
          p = int'(rd_pos) + n;
          if (p >= ring_span()) p -= ring_span();
          rd_pos = ADDR_W'(p);
        end
        REQ_FLUSH: rd_pos = wr_pos;
        REQ_COUNT: begin
          for (p = rd_pos; p != wr_pos; p = step_pos(p))
            if (store[p] == db) n++;
          r.match_count = 8'(n);
        end
        REQ_FIND: begin
          p = rd_pos;
          while (p != wr_pos && !r.flag) begin
            m = match_advance(m, store[p]);
            if (m >= plen) r.flag = 1'b1;
            p = step_pos(p);
          end
        end
        REQ_SKIP: begin
          while (rd_pos != wr_pos && m < plen) begin
            m = match_advance(m, store[rd_pos]);
            rd_pos = ADDR_W'(step_pos(rd_pos));
          end
          r.flag = (m >= plen);
        end
        REQ_CLEAR: begin
          foreach (store[i]) store[i] = '0;
          rd_pos = '0;
          wr_pos = '0;
        end
        default: ;
      endcase
      r.occupancy = 8'(fill_level());
      r.is_empty = (rd_pos == wr_pos);
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(ring_word_t got);
      ring_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t ns: result word with none expected, expected none, actual %h",
                 $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        compare_field("read_byte", want.read_byte, got.read_byte);
        compare_field("flag", 8'(want.flag), 8'(got.flag));
        compare_field("match_count", want.match_count, got.match_count);
        compare_field("occupancy", want.occupancy, got.occupancy);
        compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
      end
    endfunction
  endclass

  localparam int                   ITEM_TARGET = 1150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = CFG_PLEN + 2'd1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [3:0]           req_type = REQ_LOAD;
  logic [7:0]           data_byte = '0;
  logic [8:0]           advance_len = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           read_byte;
  logic                 flag;
  logic [7:0]           match_count;
  logic [7:0]           occupancy;
  logic                 is_empty;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;

  ring_scoreboard sb;
  int             sent;
  int             stall_left;
  bit             no_gaps;
  bit             alpha_mode;
  logic [7:0]     symbols [4];

  byte_ring_buffer_with_search_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .data_byte(data_byte), .advance_len(advance_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_byte(read_byte), .flag(flag), .match_count(match_count),
    .occupancy(occupancy), .is_empty(is_empty),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_pause();
    return no_gaps ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] pick_byte();
    if (alpha_mode && $urandom_range(0, 3) != 0) return symbols[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word({read_byte, flag, match_count, occupancy, is_empty});
      stall_left <= draw_pause();
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_left != 0);
  end

  task automatic send_req(input logic [3:0] req, input logic [7:0] db,
                          input logic [8:0] alen);
    int gap;
    gap = draw_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    data_byte <= db;
    advance_len <= alen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, db, alen);
    sent++;
    @(negedge clk);
  endtask

  // hold input and wait until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.configure(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_burst(input int span);
    int k, at, plen;
    bit embed;
    logic [7:0] b;
    k = (span <= 24 || $urandom_range(0, 9) == 0) ? $urandom_range(1, span + 1)
                                                   : $urandom_range(1, 40);
    plen = sb.pattern_len();
    at = $urandom_range(0, k - 1);
    embed = $urandom_range(0, 1);
    for (int i = 0; i < k; i++) begin
      b = (embed && i >= at && i < at + plen) ? sb.pattern_byte(i - at) : pick_byte();
      send_req(REQ_LOAD, b, 9'($urandom));
    end
  endtask

  task automatic random_req();
    int roll, span;
    logic [3:0] req;
    logic [8:0] alen;
    span = sb.ring_span();
    roll = $urandom_range(0, 99);
    alen = 9'($urandom);
    if (roll < 38)      req = REQ_LOAD;
    else if (roll < 50) req = REQ_GET;
    else if (roll < 56) req = REQ_PEEK;
    else if (roll < 64) req = REQ_ADV;
    else if (roll < 67) req = REQ_FLUSH;
    else if (roll < 75) req = REQ_COUNT;
    else if (roll < 85) req = REQ_FIND;
    else if (roll < 95) req = REQ_SKIP;
    else if (roll < 96) req = REQ_CLEAR;
    else                req = REQ_CLEAR + 4'($urandom_range(1, 7));
    if (req == REQ_ADV && $urandom_range(0, 4) != 0) alen = 9'($urandom_range(0, span));
    if (roll >= 98) load_burst(span);
    else send_req(req, pick_byte(), alen);
  endtask

  initial begin
    #40_000_000;
    $display("** byte_ring_buffer_with_search_top: FAILED **");
    $finish;
  end

  initial begin
    int ph, phase_end, roll;
    logic [8:0] size_val;
    logic [3:0] plen_val;
    logic [63:0] pat_val;
    sb = new;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_req(REQ_GET, 8'h00, 9'd0);
    send_req(REQ_PEEK, 8'hFF, 9'd0);
    send_req(REQ_FIND, 8'h00, 9'd0);
    send_req(REQ_SKIP, 8'h00, 9'd0);
    send_req(REQ_COUNT, 8'h00, 9'd0);
    send_req(REQ_ADV, 8'h00, 9'h1FF);
    send_req(REQ_LOAD, 8'h00, 9'h1FF);
    send_req(REQ_LOAD, 8'hFF, 9'd0);
    send_req(REQ_LOAD, 8'hA5, 9'd0);
    send_req(REQ_PEEK, 8'h00, 9'd0);
    send_req(REQ_COUNT, 8'hFF, 9'd0);
    send_req(REQ_FIND, 8'h00, 9'd0);
    send_req(REQ_GET, 8'h00, 9'd0);
    send_req(REQ_SKIP, 8'h00, 9'd0);
    send_req(REQ_LOAD, 8'h5A, 9'd0);
    send_req(REQ_LOAD, 8'h00, 9'd0);
    send_req(REQ_LOAD, 8'h7E, 9'd0);
    send_req(REQ_ADV, 8'h00, 9'd256);
    send_req(REQ_LOAD, 8'hFF, 9'd0);
    send_req(REQ_ADV, 8'h00, 9'd0);
    send_req(REQ_FLUSH, 8'h00, 9'd0);
    send_req(4'hF, 8'hFF, 9'h1FF);
    send_req(REQ_LOAD, 8'h01, 9'd0);
    send_req(REQ_CLEAR, 8'h00, 9'd0);
    send_req(REQ_GET, 8'h00, 9'd0);
    drain();
    write_reg(CFG_SPARE, {$urandom, $urandom});

    ph = 0;
    while (sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      alpha_mode = ($urandom_range(0, 2) != 0);
      foreach (symbols[i]) symbols[i] = 8'($urandom);
      roll = $urandom_range(0, 9);
      case (ph)
        0: size_val = 9'd0;
        1: size_val = 9'd1;
        2: size_val = 9'd2;
        3: size_val = 9'd3;
        4: size_val = 9'd511;
        5: size_val = 9'd256;
        6: size_val = 9'd257;
        default: begin
          if (roll < 7)      size_val = 9'($urandom_range(2, 24));
          else if (roll < 9) size_val = 9'($urandom_range(25, 256));
          else               size_val = 9'($urandom_range(0, 511));
        end
      endcase
      case (ph)
        0: plen_val = 4'd0;
        1: plen_val = 4'd8;
        2: plen_val = 4'd15;
        3: plen_val = 4'd1;
        default: plen_val = 4'($urandom_range(0, 15));
      endcase
      for (int i = 0; i < 8; i++)
        pat_val[i * 8 +: 8] = alpha_mode ? symbols[$urandom_range(0, 3)] : 8'($urandom);
      drain();
      write_reg(CFG_SIZE, {$urandom, 23'($urandom), size_val});
      write_reg(CFG_PATTERN, pat_val);
      write_reg(CFG_PLEN, {$urandom, 28'($urandom), plen_val});

      if (ph == 4) begin
        for (int i = 0; i < DEPTH - 1; i++) send_req(REQ_LOAD, 8'h3C, 9'($urandom));
        send_req(REQ_COUNT, 8'h3C, 9'($urandom));
        send_req(REQ_FIND, 8'($urandom), 9'($urandom));
        send_req(REQ_PEEK, 8'($urandom), 9'($urandom));
        send_req(REQ_LOAD, 8'($urandom), 9'($urandom));
      end

      phase_end = sent + $urandom_range(40, 120);
      while (sent < phase_end && sent < ITEM_TARGET) begin
        random_req();
        if ($urandom_range(0, 99) == 0) drain();
      end
      ph++;
    end

    drain();
    repeat (600) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** byte_ring_buffer_with_search_top: PASSED **");
    end else begin
      $display("** byte_ring_buffer_with_search_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/brbs_pkg.sv
sv/brbs_store.sv
sv/byte_ring_buffer_with_search_top.sv
dv/tb_byte_ring_buffer_with_search_top.sv
